>>> rtl/stx_eot_ack_frame_link_top_assert.svh
// assertion macros for the framing link engine
`ifndef STX_EOT_ACK_FRAME_LINK_TOP_ASSERT_SVH
`define STX_EOT_ACK_FRAME_LINK_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define STX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/stx_pkg.sv
// shared types, codes and constants of the framing link engine
package stx_pkg;

	localparam logic [2:0] OP_TICK       = 3'd0;
	localparam logic [2:0] OP_LINE_BYTE  = 3'd1;
	localparam logic [2:0] OP_RX_BEGIN   = 3'd2;
	localparam logic [2:0] OP_TX_BEGIN   = 3'd3;
	localparam logic [2:0] OP_PAYLOAD    = 3'd4;
	localparam logic [2:0] OP_END        = 3'd5;

	localparam logic [2:0] KIND_LINE     = 3'd0;
	localparam logic [2:0] KIND_RX_BYTE  = 3'd1;
	localparam logic [2:0] KIND_RX_DONE  = 3'd2;
	localparam logic [2:0] KIND_TX_DONE  = 3'd3;
	localparam logic [2:0] KIND_FAIL     = 3'd4;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_START_TO  = 3'd1;
	localparam logic [2:0] ERR_BAD_START = 3'd2;
	localparam logic [2:0] ERR_GAP_TO    = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd4;
	localparam logic [2:0] ERR_ACK_TO    = 3'd5;
	localparam logic [2:0] ERR_NOT_ACK   = 3'd6;

	localparam logic [7:0] BYTE_STX = 8'h02;
	localparam logic [7:0] BYTE_EOT = 8'h04;
	localparam logic [7:0] BYTE_ENQ = 8'h05;
	localparam logic [7:0] BYTE_ACK = 8'h06;

	localparam logic [1:0] REG_START_TO = 2'd0;
	localparam logic [1:0] REG_GAP_TO   = 2'd1;
	localparam logic [1:0] REG_ACK_TO   = 2'd2;
	localparam logic [1:0] REG_MAX_LEN  = 2'd3;

	localparam logic [15:0] RST_START_TO = 16'd3000;
	localparam logic [15:0] RST_GAP_TO   = 16'd5000;
	localparam logic [15:0] RST_ACK_TO   = 16'd3000;
	localparam logic [15:0] RST_MAX_LEN  = 16'd4096;

	localparam int OUT_DEPTH = 4;

	typedef struct packed {
		logic [15:0] start_to;
		logic [15:0] gap_to;
		logic [15:0] ack_to;
		logic [15:0] max_len;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  byte_value;
		logic [15:0] frame_length;
		logic [2:0]  error_code;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic res_t mk_res(logic [2:0] kind, logic [7:0] bv, logic [15:0] len,
		logic [2:0] err);
		res_t r;
		r.kind         = kind;
		r.byte_value   = bv;
		r.frame_length = len;
		r.error_code   = err;
		r.last         = 1'b0;
		return r;
	endfunction

endpackage

>>> rtl/stx_eot_ack_frame_link_top.sv
// top level of the framing link engine: input register, config registers, queue
// path: input register, then the result queue, which drives the result outputs
// throughput: one item per cycle unless stalled; a two-result item puts two words out
// the input stalls only while the result queue has no room for two words
// reset: asynchronous, clears the link to idle and loads the default register values
// no clearing pass: the block takes items from the first cycle after reset
module stx_eot_ack_frame_link_top #(
	parameter int OUT_DEPTH = stx_pkg::OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  byte_value,
	output logic [15:0] frame_length,
	output logic [2:0]  error_code,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

`include "stx_eot_ack_frame_link_top_assert.svh"

	stx_pkg::cfg_t  cfg_q;
	stx_pkg::push_t push;
	stx_pkg::res_t  head;
	logic           item_valid_s1;
	logic [2:0]     op_s1;
	logic [7:0]     data_s1;
	logic           room;
	logic           process;
	logic           accept;

	assign cfg_ready = 1'b1;
	assign process   = item_valid_s1 && room;
	assign in_stall  = item_valid_s1 && !room;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_to <= stx_pkg::RST_START_TO;
			cfg_q.gap_to   <= stx_pkg::RST_GAP_TO;
			cfg_q.ack_to   <= stx_pkg::RST_ACK_TO;
			cfg_q.max_len  <= stx_pkg::RST_MAX_LEN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				stx_pkg::REG_START_TO: cfg_q.start_to <= cfg_data;
				stx_pkg::REG_GAP_TO:   cfg_q.gap_to   <= cfg_data;
				stx_pkg::REG_ACK_TO:   cfg_q.ack_to   <= cfg_data;
				stx_pkg::REG_MAX_LEN:  cfg_q.max_len  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (process) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			data_s1 <= data;
		end
	end

	stx_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.process (process),
		.op      (op_s1),
		.data    (data_s1),
		.cfg     (cfg_q),
		.push    (push)
	);

	stx_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind         = head.kind;
	assign byte_value   = head.byte_value;
	assign frame_length = head.frame_length;
	assign error_code   = head.error_code;
	assign last         = head.last;

	`STX_ASSERT_NOW(a_pair_last, push.n == 2'd2, !push.r0.last && push.r1.last, "pair last marks wrong")
	`STX_ASSERT_NOW(a_push_room, push.n != 2'd0, process, "result pushed without a processed item")
	`STX_ASSERT_NEXT(a_push_shows, push.n != 2'd0, out_valid, "pushed result not visible")
	`STX_ASSERT_NOW(a_fail_code, out_valid && kind == stx_pkg::KIND_FAIL, error_code != stx_pkg::ERR_NONE && last, "failure word without code or last")

endmodule

>>> rtl/stx_ctrl.sv
// link state machine: state update and result words for one item
module stx_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           process,
	input  logic [2:0]     op,
	input  logic [7:0]     data,
	input  stx_pkg::cfg_t  cfg,
	output stx_pkg::push_t push
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_RX_START,
		MODE_RX_BODY,
		MODE_TX_ACK1,
		MODE_TX_BODY,
		MODE_TX_ACK2
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [15:0] wait_q, wait_d;
	logic [15:0] count_q, count_d;
	logic [15:0] wait_inc;
	logic [15:0] limit;
	logic [1:0]  n;
	stx_pkg::res_t r0, r1;

	assign wait_inc = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;

	always_comb begin
		unique case (mode_q)
			MODE_RX_START: limit = cfg.start_to;
			MODE_RX_BODY:  limit = cfg.gap_to;
			default:       limit = cfg.ack_to;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		wait_d  = wait_q;
		count_d = count_q;
		n       = 2'd0;
		r0      = stx_pkg::mk_res(stx_pkg::KIND_LINE, 8'h00, 16'h0000, stx_pkg::ERR_NONE);
		r1      = r0;
		unique case (op)
			stx_pkg::OP_RX_BEGIN: begin
				mode_d  = MODE_RX_START;
				wait_d  = '0;
				count_d = '0;
			end
			stx_pkg::OP_TX_BEGIN: begin
				mode_d  = MODE_TX_ACK1;
				wait_d  = '0;
				count_d = '0;
				n       = 2'd2;
				r0 = stx_pkg::mk_res(stx_pkg::KIND_LINE, stx_pkg::BYTE_ENQ, 16'h0000,
					stx_pkg::ERR_NONE);
				r1 = stx_pkg::mk_res(stx_pkg::KIND_LINE, stx_pkg::BYTE_STX, 16'h0000,
					stx_pkg::ERR_NONE);
			end
			stx_pkg::OP_TICK: begin
				if (mode_q == MODE_RX_START || mode_q == MODE_RX_BODY ||
					mode_q == MODE_TX_ACK1 || mode_q == MODE_TX_ACK2) begin
					wait_d = wait_inc;
					if (wait_inc >= limit) begin
						mode_d = MODE_IDLE;
						wait_d = '0;
						n      = 2'd1;
						unique case (mode_q)
							MODE_RX_START: r0 = stx_pkg::mk_res(stx_pkg::KIND_FAIL, 8'h00,
								16'h0000, stx_pkg::ERR_START_TO);
							MODE_RX_BODY: r0 = stx_pkg::mk_res(stx_pkg::KIND_FAIL, 8'h00,
								16'h0000, stx_pkg::ERR_GAP_TO);
							default: r0 = stx_pkg::mk_res(stx_pkg::KIND_FAIL, 8'h00,
								16'h0000, stx_pkg::ERR_ACK_TO);
						endcase
					end
				end
			end
			stx_pkg::OP_LINE_BYTE: begin
				unique case (mode_q)
					MODE_RX_START: begin
						n = 2'd1;
						wait_d = '0;
						if (data != stx_pkg::BYTE_STX) begin
							mode_d = MODE_IDLE;
							r0 = stx_pkg::mk_res(stx_pkg::KIND_FAIL, 8'h00, 16'h0000,
								stx_pkg::ERR_BAD_START);
						end else begin
							mode_d = MODE_RX_BODY;
							r0 = stx_pkg::mk_res(stx_pkg::KIND_LINE, stx_pkg::BYTE_ACK,
								16'h0000, stx_pkg::ERR_NONE);
						end
					end
					MODE_RX_BODY: begin
						wait_d = '0;
						if (data == stx_pkg::BYTE_EOT) begin
							mode_d = MODE_IDLE;
							n      = 2'd2;
							r0 = stx_pkg::mk_res(stx_pkg::KIND_LINE, stx_pkg::BYTE_ACK,
								16'h0000, stx_pkg::ERR_NONE);
							r1 = stx_pkg::mk_res(stx_pkg::KIND_RX_DONE, 8'h00, count_q,
								stx_pkg::ERR_NONE);
						end else if (count_q >= cfg.max_len) begin
							mode_d = MODE_IDLE;
							n      = 2'd1;
							r0 = stx_pkg::mk_res(stx_pkg::KIND_FAIL, 8'h00, 16'h0000,
								stx_pkg::ERR_OVERFLOW);
						end else begin
							count_d = count_q + 16'd1;
							n       = 2'd1;
							r0 = stx_pkg::mk_res(stx_pkg::KIND_RX_BYTE, data, 16'h0000,
								stx_pkg::ERR_NONE);
						end
					end
					MODE_TX_ACK1, MODE_TX_ACK2: begin
						wait_d = '0;
						if (data != stx_pkg::BYTE_ACK) begin
							mode_d = MODE_IDLE;
							n      = 2'd1;
							r0 = stx_pkg::mk_res(stx_pkg::KIND_FAIL, 8'h00, 16'h0000,
								stx_pkg::ERR_NOT_ACK);
						end else if (mode_q == MODE_TX_ACK1) begin
							mode_d = MODE_TX_BODY;
						end else begin
							mode_d = MODE_IDLE;
							n      = 2'd1;
							r0 = stx_pkg::mk_res(stx_pkg::KIND_TX_DONE, 8'h00, 16'h0000,
								stx_pkg::ERR_NONE);
						end
					end
					default: begin
					end
				endcase
			end
			stx_pkg::OP_PAYLOAD: begin
				if (mode_q == MODE_TX_BODY) begin
					n  = 2'd1;
					r0 = stx_pkg::mk_res(stx_pkg::KIND_LINE, data, 16'h0000,
						stx_pkg::ERR_NONE);
				end
			end
			stx_pkg::OP_END: begin
				if (mode_q == MODE_TX_BODY) begin
					mode_d = MODE_TX_ACK2;
					wait_d = '0;
					n      = 2'd1;
					r0 = stx_pkg::mk_res(stx_pkg::KIND_LINE, stx_pkg::BYTE_EOT, 16'h0000,
						stx_pkg::ERR_NONE);
				end
			end
			default: begin
			end
		endcase
		r0.last = (n == 2'd1);
		r1.last = 1'b1;
	end

	always_comb begin
		push.n  = process ? n : 2'd0;
		push.r0 = r0;
		push.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			wait_q  <= '0;
			count_q <= '0;
		end else if (process) begin
			mode_q  <= mode_d;
			wait_q  <= wait_d;
			count_q <= count_d;
		end
	end

endmodule

>>> rtl/stx_out_fifo.sv
// result queue: takes up to two words a cycle, hands out one
module stx_out_fifo #(
	parameter int DEPTH = stx_pkg::OUT_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  stx_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_stall,
	output stx_pkg::res_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	stx_pkg::res_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q, wr_next;
	logic [CW-1:0]   count_q;
	logic            pop;

	function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_next   = inc(wr_q);
	assign out_valid = (count_q != '0);
	assign room      = (count_q <= CW'(DEPTH - 2));
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			unique case (push.n)
				2'd1:    wr_q <= wr_next;
				2'd2:    wr_q <= inc(wr_next);
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= inc(rd_q);
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

endmodule

>>> tb/tb_stx_eot_ack_frame_link_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the framing link engine top level
module tb_stx_eot_ack_frame_link_top;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 100;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_RX_START,
		MODE_RX_BODY,
		MODE_TX_ACK1,
		MODE_TX_BODY,
		MODE_TX_ACK2
	} link_mode_t;

	class link_result_predictor;
		logic [15:0]   start_to;
		logic [15:0]   gap_to;
		logic [15:0]   ack_to;
		logic [15:0]   max_len;
		link_mode_t    mode;
		logic [15:0]   wait_cnt;
		logic [15:0]   byte_cnt;
		stx_pkg::res_t step_words[$];
		stx_pkg::res_t expected_words[$];
		int            mismatches;
		int            checked;
		int            rx_frames;
		int            tx_frames;
		int            fail_reports;

		function new();
			start_to = stx_pkg::RST_START_TO;
			gap_to   = stx_pkg::RST_GAP_TO;
			ack_to   = stx_pkg::RST_ACK_TO;
			max_len  = stx_pkg::RST_MAX_LEN;
			mode     = MODE_IDLE;
			wait_cnt = '0;
			byte_cnt = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] v);
			case (idx)
				stx_pkg::REG_START_TO: start_to = v;
				stx_pkg::REG_GAP_TO:   gap_to = v;
				stx_pkg::REG_ACK_TO:   ack_to = v;
				stx_pkg::REG_MAX_LEN:  max_len = v;
				default: ;
			endcase
		endfunction

		function void stage(logic [2:0] k, logic [7:0] b, logic [15:0] len, logic [2:0] err);
			step_words.push_back({k, b, len, err, 1'b0});
		endfunction

		// returns 0 when the block ignores the word
		function bit note_input(logic [2:0] o, logic [7:0] d);
			logic [15:0] lim;
			logic [2:0]  err;
			bit          acted;
			acted = 1'b1;
			err = stx_pkg::ERR_NONE;
			lim = '0;
			step_words.delete();
			case (o)
				stx_pkg::OP_RX_BEGIN: begin
					mode = MODE_RX_START;
					wait_cnt = '0;
					byte_cnt = '0;
				end
				stx_pkg::OP_TX_BEGIN: begin
					mode = MODE_TX_ACK1;
					wait_cnt = '0;
					byte_cnt = '0;
					stage(stx_pkg::KIND_LINE, stx_pkg::BYTE_ENQ, 16'd0, stx_pkg::ERR_NONE);
					stage(stx_pkg::KIND_LINE, stx_pkg::BYTE_STX, 16'd0, stx_pkg::ERR_NONE);
				end
				stx_pkg::OP_TICK: begin
					case (mode)
						MODE_RX_START: lim = start_to;
						MODE_RX_BODY: lim = gap_to;
						MODE_TX_ACK1, MODE_TX_ACK2: lim = ack_to;
						default: acted = 1'b0;
					endcase
					if (acted) begin
						if (wait_cnt != 16'hffff)
							wait_cnt++;
						if (wait_cnt >= lim)
							err = (mode == MODE_RX_START) ? stx_pkg::ERR_START_TO :
								(mode == MODE_RX_BODY) ? stx_pkg::ERR_GAP_TO :
								stx_pkg::ERR_ACK_TO;
					end
				end
				stx_pkg::OP_LINE_BYTE: begin
					case (mode)
						MODE_RX_START: begin
							if (d != stx_pkg::BYTE_STX) begin
								err = stx_pkg::ERR_BAD_START;
							end else begin
								mode = MODE_RX_BODY;
								wait_cnt = '0;
								stage(stx_pkg::KIND_LINE, stx_pkg::BYTE_ACK, 16'd0,
									stx_pkg::ERR_NONE);
							end
						end
						MODE_RX_BODY: begin
							wait_cnt = '0;
							if (d == stx_pkg::BYTE_EOT) begin
								mode = MODE_IDLE;
								stage(stx_pkg::KIND_LINE, stx_pkg::BYTE_ACK, 16'd0,
									stx_pkg::ERR_NONE);
								stage(stx_pkg::KIND_RX_DONE, 8'd0, byte_cnt,
									stx_pkg::ERR_NONE);
							end else if (byte_cnt >= max_len) begin
								err = stx_pkg::ERR_OVERFLOW;
							end else begin
								byte_cnt++;
								stage(stx_pkg::KIND_RX_BYTE, d, 16'd0, stx_pkg::ERR_NONE);
							end
						end
						MODE_TX_ACK1: begin
							if (d != stx_pkg::BYTE_ACK) begin
								err = stx_pkg::ERR_NOT_ACK;
							end else begin
								mode = MODE_TX_BODY;
								wait_cnt = '0;
							end
						end
						MODE_TX_ACK2: begin
							if (d != stx_pkg::BYTE_ACK) begin
								err = stx_pkg::ERR_NOT_ACK;
							end else begin
								mode = MODE_IDLE;
								wait_cnt = '0;
								stage(stx_pkg::KIND_TX_DONE, 8'd0, 16'd0, stx_pkg::ERR_NONE);
							end
						end
						default: acted = 1'b0;
					endcase
				end
				stx_pkg::OP_PAYLOAD: begin
					if (mode == MODE_TX_BODY)
						stage(stx_pkg::KIND_LINE, d, 16'd0, stx_pkg::ERR_NONE);
					else
						acted = 1'b0;
				end
				stx_pkg::OP_END: begin
					if (mode == MODE_TX_BODY) begin
						mode = MODE_TX_ACK2;
						wait_cnt = '0;
						stage(stx_pkg::KIND_LINE, stx_pkg::BYTE_EOT, 16'd0, stx_pkg::ERR_NONE);
					end else begin
						acted = 1'b0;
					end
				end
				default: acted = 1'b0;
			endcase
			if (err != stx_pkg::ERR_NONE) begin
				mode = MODE_IDLE;
				wait_cnt = '0;
				stage(stx_pkg::KIND_FAIL, 8'd0, 16'd0, err);
			end
			if (step_words.size() != 0)
				step_words[step_words.size() - 1].last = 1'b1;
			foreach (step_words[i])
				expected_words.push_back(step_words[i]);
			return acted;
		endfunction

		function void report(string what, stx_pkg::res_t want, stx_pkg::res_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%s: expected kind %0d byte %02h len %0d err %0d last %b, got kind %0d byte %02h len %0d err %0d last %b",
					what, want.kind, want.byte_value, want.frame_length, want.error_code,
					want.last, got.kind, got.byte_value, got.frame_length, got.error_code,
					got.last);
		endfunction

		function void check_result(stx_pkg::res_t got);
			stx_pkg::res_t want;
			checked++;
			case (got.kind)
				stx_pkg::KIND_RX_DONE: rx_frames++;
				stx_pkg::KIND_TX_DONE: tx_frames++;
				stx_pkg::KIND_FAIL:    fail_reports++;
				default: ;
			endcase
			if (expected_words.size() == 0) begin
				report("unexpected word (none pending)", '0, got);
				return;
			end
			want = expected_words.pop_front();
			if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
				got.frame_length !== want.frame_length ||
				got.error_code !== want.error_code || got.last !== want.last)
				report("mismatch", want, got);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = stx_pkg::OP_TICK;
	logic [7:0]  data = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  byte_value;
	logic [15:0] frame_length;
	logic [2:0]  error_code;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = stx_pkg::REG_START_TO;
	logic [15:0] cfg_data = 16'd0;

	link_result_predictor sb;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int acted_items;
	int sent_items;
	int settings_run;
	int cycles;

	stx_eot_ack_frame_link_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.data        (data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.byte_value  (byte_value),
		.frame_length(frame_length),
		.error_code  (error_code),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_stx_eot_ack_frame_link_top: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin : result_side
		stx_pkg::res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, byte_value, frame_length, error_code, last};
			sb.check_result(got);
		end
		out_stall <= rx_idle_en && ($urandom_range(99) < 34);
	end

	task automatic drive_item(input logic [2:0] o, input logic [7:0] d);
		while (tx_idle_en && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		data <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
		if (sb.note_input(o, d))
			acted_items++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			drive_item(stx_pkg::OP_TICK, 8'($urandom));
	endtask

	// mostly under the limit, sometimes right on it when the limit is 16 or less
	function automatic int pick_ticks(logic [15:0] lim);
		int cap;
		if (lim > 16)
			return $urandom_range(0, 3);
		if ($urandom_range(4) == 0)
			return int'(lim);
		cap = (lim > 5) ? 4 : int'(lim) - 1;
		return $urandom_range(0, cap);
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_regs(input logic [15:0] s, input logic [15:0] g,
		input logic [15:0] a, input logic [15:0] m);
		logic [1:0]  idx[4];
		logic [15:0] vals[4];
		idx = '{stx_pkg::REG_START_TO, stx_pkg::REG_GAP_TO, stx_pkg::REG_ACK_TO,
			stx_pkg::REG_MAX_LEN};
		vals = '{s, g, a, m};
		cfg_valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.set_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	task automatic rx_frame();
		int top;
		logic [7:0] b;
		drive_item(stx_pkg::OP_RX_BEGIN, 8'($urandom));
		send_ticks(pick_ticks(sb.start_to));
		if ($urandom_range(9) == 0)
			drive_item(stx_pkg::OP_LINE_BYTE, 8'($urandom));
		else
			drive_item(stx_pkg::OP_LINE_BYTE, stx_pkg::BYTE_STX);
		top = (sb.max_len <= 20) ? int'(sb.max_len) + 2 : 12;
		repeat ($urandom_range(0, top)) begin
			if ($urandom_range(3) == 0)
				send_ticks(pick_ticks(sb.gap_to));
			b = 8'($urandom);
			drive_item(stx_pkg::OP_LINE_BYTE, b);
		end
		if ($urandom_range(9) != 0)
			drive_item(stx_pkg::OP_LINE_BYTE, stx_pkg::BYTE_EOT);
	endtask

	task automatic tx_frame();
		drive_item(stx_pkg::OP_TX_BEGIN, 8'($urandom));
		send_ticks(pick_ticks(sb.ack_to));
		drive_item(stx_pkg::OP_LINE_BYTE,
			($urandom_range(6) == 0) ? 8'($urandom) : stx_pkg::BYTE_ACK);
		repeat ($urandom_range(0, 10)) begin
			case ($urandom_range(7))
				0: drive_item(stx_pkg::OP_TICK, 8'($urandom));
				1: drive_item(stx_pkg::OP_LINE_BYTE, 8'($urandom));
				default: ;
			endcase
			drive_item(stx_pkg::OP_PAYLOAD, 8'($urandom));
		end
		if ($urandom_range(9) != 0) begin
			drive_item(stx_pkg::OP_END, 8'($urandom));
			send_ticks(pick_ticks(sb.ack_to));
			drive_item(stx_pkg::OP_LINE_BYTE,
				($urandom_range(6) == 0) ? 8'($urandom) : stx_pkg::BYTE_ACK);
		end
	endtask

	task automatic run_phase(input int target);
		int base;
		base = sent_items;
		while (sent_items - base < target) begin
			case ($urandom_range(9))
				0, 1, 2, 3: rx_frame();
				4, 5, 6, 7: tx_frame();
				default: begin
					repeat ($urandom_range(1, 4))
						drive_item(3'($urandom), 8'($urandom));
				end
			endcase
		end
		drain();
	endtask

	task automatic directed();
		// stray words in idle
		drive_item(stx_pkg::OP_TICK, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, 8'hff);
		drive_item(OP_SPARE6, 8'h00);
		drive_item(OP_SPARE7, 8'hff);
		drive_item(stx_pkg::OP_PAYLOAD, 8'h5a);
		drive_item(stx_pkg::OP_END, 8'h00);
		// clean receive with extreme payload bytes
		drive_item(stx_pkg::OP_RX_BEGIN, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, stx_pkg::BYTE_STX);
		drive_item(stx_pkg::OP_LINE_BYTE, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, 8'hff);
		drive_item(stx_pkg::OP_TICK, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, stx_pkg::BYTE_EOT);
		// wrong start byte
		drive_item(stx_pkg::OP_RX_BEGIN, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, 8'h41);
		// send with ignored tick and line byte, then a non-ack reply
		drive_item(stx_pkg::OP_TX_BEGIN, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, stx_pkg::BYTE_ACK);
		drive_item(stx_pkg::OP_PAYLOAD, 8'h00);
		drive_item(stx_pkg::OP_PAYLOAD, 8'hff);
		drive_item(stx_pkg::OP_TICK, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, 8'h55);
		drive_item(stx_pkg::OP_END, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, 8'h15);
		// begin while busy aborts silently
		drive_item(stx_pkg::OP_TX_BEGIN, 8'h00);
		drive_item(stx_pkg::OP_RX_BEGIN, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, stx_pkg::BYTE_STX);
		drive_item(stx_pkg::OP_TX_BEGIN, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, stx_pkg::BYTE_ACK);
		drive_item(stx_pkg::OP_END, 8'h00);
		drive_item(stx_pkg::OP_LINE_BYTE, stx_pkg::BYTE_ACK);
	endtask

	initial begin
		sb = new();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		drain();

		write_regs(16'd1, 16'd1, 16'd1, 16'd0);
		run_phase(PHASE_ITEMS);
		write_regs(16'd3, 16'd5, 16'd4, 16'd8);
		run_phase(PHASE_ITEMS);

		// no idling on either side here
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_regs(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
			16'($urandom_range(1, 12)), 16'($urandom_range(0, 20)));
		run_phase(PHASE_ITEMS);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;

		write_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		run_phase(PHASE_ITEMS);
		write_regs(16'd2, 16'hffff, 16'd1, 16'hffff);
		run_phase(PHASE_ITEMS);
		write_regs(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
			16'($urandom_range(1, 12)), 16'($urandom_range(0, 20)));
		run_phase(PHASE_ITEMS);
		write_regs(16'hffff, 16'd2, 16'd3, 16'd1);
		run_phase(PHASE_ITEMS);

		$display("covered %0d input words (%0d effective) over %0d register settings, %0d result words checked",
			sent_items, acted_items, settings_run, sb.checked);
		$display("frames received %0d, frames sent %0d, failure reports %0d, mismatches %0d",
			sb.rx_frames, sb.tx_frames, sb.fail_reports, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
			$display("tb_stx_eot_ack_frame_link_top: done, clean");
		end else begin
			$display("tb_stx_eot_ack_frame_link_top: done, errors");
		end
		$finish;
	end

endmodule
